### hdl/wrsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_pkg: shared types and constants for the Wilder RSI stream block
// Field widths, fixed RSI scale, controller commands and datapath status.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    localparam int PRICE_IN_W = 32;   // close_price field width
    localparam int PERIOD_W   = 8;    // period register width
    localparam int RSI_W      = 15;   // rsi_scaled field width

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
    localparam logic [RSI_W-1:0]    RSI_FULL     = 15'd25600;  // 100 * 256

    // Where the stream stands after the current item was taken in
    typedef enum logic [1:0] {
        PH_WARM,   // still summing the initial window
        PH_SEED,   // this item completes the window: seed averages
        PH_UPD     // averages already seeded: smoothing update
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take in a price beat
        logic mul_avg;    // product <= average * (period - 1)
        logic mul_rsi;    // product <= gain average * RSI_FULL
        logic div_start;  // start the shared divider
        logic div_rsi;    // divider job is the RSI ratio, else an average
        logic lane;       // 0: gain, 1: loss
        logic avg_wr;     // average of lane <= quotient
        logic rsi_fix;    // RSI <= fixed value (100 or 0)
        logic rsi_wr;     // RSI <= quotient
        logic out_load;   // output register <= result
    } wrsi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        phase_t phase;
        logic   rsi_trivial;  // RSI needs no division
        logic   div_busy;
        logic   div_done;
    } wrsi_stat_t;

endpackage
`default_nettype wire

### hdl/wrsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_div: shared restoring divider, one quotient bit per cycle
// Runs AVG_W steps for an average job, RSI_W steps for the RSI ratio. The
// quotient is known to fit that many bits, so the upper dividend bits seed
// the partial remainder directly.
// ----------------------------------------------------------------------------
module wrsi_div #(
    parameter int AVG_W = 48
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             rsi_mode,
    input  wire logic [AVG_W+wrsi_pkg::RSI_W-1:0] dividend,
    input  wire logic [AVG_W:0]                   divisor,
    output logic                                  busy,
    output logic                                  done,
    output logic [AVG_W-1:0]                      quotient
);
    import wrsi_pkg::*;

    localparam int NUM_W = AVG_W + RSI_W;
    localparam int DEN_W = AVG_W + 1;
    localparam int CNT_W = $clog2(AVG_W + 1);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [AVG_W-1:0] dvd_reg,  dvd_next;
    logic [DEN_W-1:0] den_reg,  den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // one compare/subtract step
    assign trial = {rem_reg, dvd_reg[AVG_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        if (start)
        begin
            den_next = divisor;
            if (rsi_mode)
            begin
                rem_next = DEN_W'(dividend[NUM_W-1:RSI_W]);
                dvd_next = AVG_W'(dividend[RSI_W-1:0]) << (AVG_W - RSI_W);
                cnt_next = CNT_W'(RSI_W);
            end
            else
            begin
                rem_next = DEN_W'(dividend[NUM_W-1:AVG_W]);
                dvd_next = dividend[AVG_W-1:0];
                cnt_next = CNT_W'(AVG_W);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            dvd_next  = {dvd_reg[AVG_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

### hdl/wrsi_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_dp: RSI datapath
// Period register, previous price, window counter, gain/loss averages, one
// shared multiplier, the shared divider and the output payload register.
// ----------------------------------------------------------------------------
module wrsi_dp #(
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [wrsi_pkg::PERIOD_W-1:0]     cfg_wdata,
    input  wire logic [wrsi_pkg::PRICE_IN_W-1:0]   price_in,
    input  wire wrsi_pkg::wrsi_cmd_t               cmd,
    output wrsi_pkg::wrsi_stat_t                   stat,
    output logic [wrsi_pkg::RSI_W-1:0]             rsi_scaled,
    output logic                                   seeded
);
    import wrsi_pkg::*;

    localparam int AVG_W = PRICE_BITS + FRAC_BITS;
    localparam int NUM_W = AVG_W + RSI_W;
    localparam int DEN_W = AVG_W + 1;

    // stream state
    logic [PERIOD_W-1:0]   period_reg;
    logic [PRICE_BITS-1:0] prev_reg;
    logic [PERIOD_W-1:0]   seen_reg;
    logic [AVG_W-1:0]      gain_reg;
    logic [AVG_W-1:0]      loss_reg;
    phase_t                phase_reg;

    // per-item payload
    logic [PRICE_BITS-1:0] xg_reg;
    logic [PRICE_BITS-1:0] xl_reg;
    logic [NUM_W-1:0]      prod_reg;
    logic [RSI_W-1:0]      rsi_reg;
    logic [RSI_W-1:0]      out_rsi_reg;
    logic                  out_seeded_reg;

    logic [PRICE_BITS-1:0] price;
    logic                  first_item;
    logic [PRICE_BITS-1:0] x_gain;
    logic [PRICE_BITS-1:0] x_loss;
    logic                  warm;
    logic [PERIOD_W-1:0]   seen_inc;
    logic [PERIOD_W-1:0]   pm1;

    logic [AVG_W-1:0]      mul_a;
    logic [RSI_W-1:0]      mul_b;
    logic [NUM_W-1:0]      mul_res;

    logic [AVG_W-1:0]      avg_sel;
    logic [PRICE_BITS-1:0] x_sel;
    logic [NUM_W-1:0]      seed_num;
    logic [NUM_W-1:0]      upd_num;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [AVG_W-1:0]      div_q;
    logic                  div_busy;
    logic                  div_done;

    // gain and loss against the previous price
    assign price      = PRICE_BITS'(price_in);
    assign first_item = (seen_reg == '0);
    assign x_gain     = (!first_item && price >= prev_reg) ? price - prev_reg : '0;
    assign x_loss     = (!first_item && price <  prev_reg) ? prev_reg - price : '0;
    assign warm       = (seen_reg < period_reg);
    assign seen_inc   = seen_reg + 1'b1;
    assign pm1        = period_reg - 1'b1;

    // shared multiplier
    assign mul_a   = (cmd.mul_rsi || !cmd.lane) ? gain_reg : loss_reg;
    assign mul_b   = cmd.mul_rsi ? RSI_FULL : RSI_W'(pm1);
    assign mul_res = NUM_W'(mul_a) * NUM_W'(mul_b);

    // divider operands
    assign avg_sel  = cmd.lane ? loss_reg : gain_reg;
    assign x_sel    = cmd.lane ? xl_reg : xg_reg;
    assign seed_num = NUM_W'(avg_sel) << FRAC_BITS;
    assign upd_num  = prod_reg + (NUM_W'(x_sel) << FRAC_BITS);
    assign div_num  = cmd.div_rsi ? prod_reg
                    : ((phase_reg == PH_SEED) ? seed_num : upd_num);
    assign div_den  = cmd.div_rsi ? (DEN_W'(gain_reg) + DEN_W'(loss_reg))
                    : DEN_W'(period_reg);

    wrsi_div #(
        .AVG_W (AVG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .rsi_mode (cmd.div_rsi),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // stream state: period write restarts the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            prev_reg   <= '0;
            seen_reg   <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
            phase_reg  <= PH_WARM;
        end
        else if (cfg_we)
        begin
            period_reg <= (cfg_wdata == '0) ? PERIOD_W'(1) : cfg_wdata;
            prev_reg   <= '0;
            seen_reg   <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
            phase_reg  <= PH_WARM;
        end
        else if (cmd.load)
        begin
            prev_reg <= price;
            if (warm)
            begin
                gain_reg  <= gain_reg + AVG_W'(x_gain);
                loss_reg  <= loss_reg + AVG_W'(x_loss);
                seen_reg  <= seen_inc;
                phase_reg <= (seen_inc == period_reg) ? PH_SEED : PH_WARM;
            end
            else
            begin
                phase_reg <= PH_UPD;
            end
        end
        else if (cmd.avg_wr)
        begin
            if (cmd.lane)
            begin
                loss_reg <= div_q;
            end
            else
            begin
                gain_reg <= div_q;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xg_reg <= x_gain;
            xl_reg <= x_loss;
        end
        if (cmd.mul_avg || cmd.mul_rsi)
        begin
            prod_reg <= mul_res;
        end
        if (cmd.rsi_fix)
        begin
            rsi_reg <= (phase_reg == PH_WARM || loss_reg == '0) ? RSI_FULL : '0;
        end
        else if (cmd.rsi_wr)
        begin
            rsi_reg <= div_q[RSI_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_rsi_reg    <= rsi_reg;
            out_seeded_reg <= (phase_reg != PH_WARM);
        end
    end

    // status
    always_comb
    begin
        stat.phase       = phase_reg;
        stat.rsi_trivial = (phase_reg == PH_WARM) || (loss_reg == '0) || (gain_reg == '0);
        stat.div_busy    = div_busy;
        stat.div_done    = div_done;
    end

    assign rsi_scaled = out_rsi_reg;
    assign seeded     = out_seeded_reg;

endmodule
`default_nettype wire

### hdl/wrsi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_ctrl: RSI sequencer
// Walks one item through the average updates and the RSI ratio, and owns
// the input ready and the output valid flag.
// ----------------------------------------------------------------------------
module wrsi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire wrsi_pkg::wrsi_stat_t stat,
    output wrsi_pkg::wrsi_cmd_t       cmd
);
    import wrsi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_RSI_CHK,
        S_RSI_MUL,
        S_RSI_DIV,
        S_RSI_WAIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   lane_reg,  lane_next;
    logic   out_full_reg, out_full_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_full_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        cmd        = '0;
        cmd.lane   = lane_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                lane_next = 1'b0;
                case (stat.phase)
                    PH_SEED: state_next = S_DIV;
                    PH_UPD:  state_next = S_MUL;
                    default: state_next = S_RSI_CHK;
                endcase
            end
            S_MUL:
            begin
                cmd.mul_avg = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.avg_wr = 1'b1;
                    if (!lane_reg)
                    begin
                        lane_next  = 1'b1;
                        state_next = (stat.phase == PH_UPD) ? S_MUL : S_DIV;
                    end
                    else
                    begin
                        state_next = S_RSI_CHK;
                    end
                end
            end
            S_RSI_CHK:
            begin
                if (stat.rsi_trivial)
                begin
                    cmd.rsi_fix = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_RSI_MUL;
                end
            end
            S_RSI_MUL:
            begin
                cmd.mul_rsi = 1'b1;
                state_next  = S_RSI_DIV;
            end
            S_RSI_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_rsi   = 1'b1;
                state_next    = S_RSI_WAIT;
            end
            S_RSI_WAIT:
            begin
                cmd.div_rsi = 1'b1;
                if (stat.div_done)
                begin
                    cmd.rsi_wr = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // wait for the output register to free up
                if (!out_full_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat holding flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_full_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_full_next = 1'b0;
        end
        else
        begin
            out_full_next = out_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lane_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lane_reg     <= lane_next;
            out_full_reg <= out_full_next;
        end
    end

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // divider never restarted while running
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    // divider only finishes while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_WAIT || state_reg == S_RSI_WAIT))
        else $error("divider finished outside a wait state");

    // a loaded result is presented next cycle
    a_out_show: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result loaded but not presented");

endmodule
`default_nettype wire

### hdl/wilder_rsi_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wilder_rsi_stream_top: streaming Wilder relative strength index
// Usage:
//   Slave channel s_* takes one closing price per beat (s_tdata). Master
//   channel m_* gives one result beat per price: RSI * 256 in m_tdata and
//   the seeded flag in m_tuser. The period register is written through
//   cfg_we/cfg_wdata while the block is idle; a write of 0 means 1, and any
//   write restarts the stream (the next price counts as a first price).
//   Sequencing: one item is processed at a time, paced by the shared one-bit-
//   per-cycle divider. A smoothing item runs a multiply and a division for
//   each average, then the ratio multiply and division unless the RSI is
//   fixed at 100 or 0; the seeding item skips the average multiplies, and a
//   warmup item runs no division. The divider runs PRICE_BITS+FRAC_BITS
//   steps per average and 15 steps for the ratio.
//   The result register is separate from the sequencer: a stalled m_tready
//   does not block accepting and processing the next price; only the
//   following result waits until the held beat is taken.
//   Reset: period returns to 10, the stream state clears, no beat is
//   pending and s_tready is high.
// ----------------------------------------------------------------------------
module wilder_rsi_stream_top #(
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // period register
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // price stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] close_price
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [14:0] rsi_scaled, [15] zero
    output logic             m_tuser    // [0] seeded
);
    import wrsi_pkg::*;

    wrsi_cmd_t        cmd;
    wrsi_stat_t       stat;
    logic [RSI_W-1:0] rsi_scaled;
    logic             seeded;

    wrsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrsi_dp #(
        .PRICE_BITS (PRICE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .price_in   (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .rsi_scaled (rsi_scaled),
        .seeded     (seeded)
    );

    assign m_tdata = {1'b0, rsi_scaled};
    assign m_tuser = seeded;

endmodule
`default_nettype wire
